### hw/rtl/assert_macros.svh
// Assertion macros used by the fault code table datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the house clock clk_i and reset rst_ni.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/fct_pkg.sv
// Shared types, codes and constants of the fault code table.
package fct_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned CODE_W = 24;
  localparam int unsigned STAT_W = 8;
  localparam int unsigned SEV_W  = 8;
  localparam int unsigned TIME_W = 32;

  localparam logic [STAT_W-1:0] ST_TEST_FAILED = 8'h01;
  localparam logic [STAT_W-1:0] ST_CONFIRMED   = 8'h08;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_REPORT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_FULL      = 2'd1,
    RC_NOT_FOUND = 2'd2
  } rc_e;

  // Source of the entry fields of a result.
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_ENT,
    SEL_RD
  } sel_e;

  // Source of a table write.
  typedef enum logic [1:0] {
    WR_HIT,
    WR_NEW,
    WR_SHIFT
  } wr_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SET_HIT,
    S_SET_NEW,
    S_SHIFT,
    S_RESP_OK,
    S_RESP_FULL,
    S_RESP_NF,
    S_RESP_ENT,
    S_RESP_LOOK,
    S_RPT_RD,
    S_RPT_OUT
  } state_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [STAT_W-1:0] status;
    logic [SEV_W-1:0]  sev;
    logic [TIME_W-1:0] first;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic    in_ready;
    logic    rd_en;
    logic    ptr_inc;
    logic    ptr_load_hit;
    logic    ent_cap;
    logic    wr_en;
    wr_src_e wr_src;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    out_load;
    rc_e     out_rc;
    sel_e    out_sel;
    logic    out_act;
    logic    out_last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  op;
    logic code_zero;
    logic ptr_lt_cnt;
    logic rd_vld;
    logic hit;
    logic cnt_zero;
    logic cnt_full;
    logic rpt_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/fault_code_table_top.sv
// Top level of the diagnostic fault code table.
//
// Holds up to ENTRIES fault codes packed into slots 0 to count-1 in order of first
// occurrence. One request is taken at a time: the block stalls its input from the
// transfer of a request until its last result is loaded into the output register,
// which then waits for its own transfer while the next request may come in. The
// table sits in a memory with one write and one registered read port, and that
// single read port sets the timing. A set or a lookup reads one slot per cycle
// until the first match or the end of the table; a set then updates the matched
// entry or appends a new one. A clear moves each later entry down one slot; a
// clear of code zero empties the table without a scan. A report reads and returns
// the stored entries one at a time.
// Every result carries the entry count after the request; last marks the final one.
module fault_code_table_top import fct_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [CODE_W-1:0] fault_code_i,
  input  logic [SEV_W-1:0]  severity_i,
  input  logic [TIME_W-1:0] now_ms_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        result_code_o,
  output logic              entry_valid_o,
  output logic [CODE_W-1:0] fault_code_out_o,
  output logic [STAT_W-1:0] status_bits_o,
  output logic [SEV_W-1:0]  severity_out_o,
  output logic [TIME_W-1:0] first_time_o,
  output logic              active_o,
  output logic [CNT_W-1:0]  entry_count_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_acc;

  // Take a request only while the sequencer is idle.
  assign in_stall_o = !cmd.in_ready;
  assign in_acc     = in_valid_i && cmd.in_ready;

  fct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_acc_i (in_acc),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  fct_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_acc_i         (in_acc),
    .op_i             (op_i),
    .fault_code_i     (fault_code_i),
    .severity_i       (severity_i),
    .now_ms_i         (now_ms_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .result_code_o    (result_code_o),
    .entry_valid_o    (entry_valid_o),
    .fault_code_out_o (fault_code_out_o),
    .status_bits_o    (status_bits_o),
    .severity_out_o   (severity_out_o),
    .first_time_o     (first_time_o),
    .active_o         (active_o),
    .entry_count_o    (entry_count_o),
    .last_o           (last_o)
  );

endmodule

### hw/rtl/fct_ctrl.sv
// Sequencing state machine of the fault code table.
module fct_ctrl import fct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_acc_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  logic scan_done;
  assign scan_done = !sts_i.ptr_lt_cnt && !sts_i.rd_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.op == OP_CLEAR && sts_i.code_zero) begin
          state_d = S_RESP_OK;
        end else if (sts_i.op == OP_REPORT) begin
          state_d = sts_i.cnt_zero ? S_RESP_OK : S_RPT_RD;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          case (sts_i.op)
            OP_SET:    state_d = S_SET_HIT;
            OP_CLEAR:  state_d = S_SHIFT;
            OP_LOOKUP: state_d = S_RESP_LOOK;
            default:   state_d = S_RESP_NF;
          endcase
        end else if (scan_done) begin
          if (sts_i.op == OP_SET) begin
            state_d = sts_i.cnt_full ? S_RESP_FULL : S_SET_NEW;
          end else begin
            state_d = S_RESP_NF;
          end
        end
      end
      S_SET_HIT: state_d = S_RESP_ENT;
      S_SET_NEW: state_d = S_RESP_ENT;
      S_SHIFT: begin
        if (scan_done) state_d = S_RESP_OK;
      end
      S_RESP_OK, S_RESP_FULL, S_RESP_NF, S_RESP_ENT, S_RESP_LOOK: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_RPT_RD: state_d = S_RPT_OUT;
      S_RPT_OUT: begin
        if (sts_i.out_free) state_d = sts_i.rpt_last ? S_IDLE : S_RPT_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o          = '0;
    cmd_o.wr_src   = WR_HIT;
    cmd_o.out_rc   = RC_OK;
    cmd_o.out_sel  = SEL_NONE;
    cmd_o.out_last = 1'b1;
    case (state_q)
      S_IDLE: cmd_o.in_ready = 1'b1;
      S_DECODE: begin
        cmd_o.cnt_clr = (sts_i.op == OP_CLEAR) && sts_i.code_zero;
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.ent_cap      = 1'b1;
          cmd_o.ptr_load_hit = 1'b1;
        end else begin
          cmd_o.rd_en   = sts_i.ptr_lt_cnt;
          cmd_o.ptr_inc = sts_i.ptr_lt_cnt;
        end
      end
      S_SET_HIT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_HIT;
      end
      S_SET_NEW: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = WR_NEW;
        cmd_o.cnt_inc = 1'b1;
      end
      S_SHIFT: begin
        cmd_o.rd_en   = sts_i.ptr_lt_cnt;
        cmd_o.ptr_inc = sts_i.ptr_lt_cnt;
        cmd_o.wr_en   = sts_i.rd_vld;
        cmd_o.wr_src  = WR_SHIFT;
        cmd_o.cnt_dec = scan_done;
      end
      S_RESP_OK: begin
        cmd_o.out_load = sts_i.out_free;
      end
      S_RESP_FULL: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_rc   = RC_FULL;
      end
      S_RESP_NF: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_rc   = RC_NOT_FOUND;
      end
      S_RESP_ENT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = SEL_ENT;
      end
      S_RESP_LOOK: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = SEL_ENT;
        cmd_o.out_act  = 1'b1;
      end
      S_RPT_RD: cmd_o.rd_en = 1'b1;
      S_RPT_OUT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = SEL_RD;
        cmd_o.out_last = sts_i.rpt_last;
        cmd_o.ptr_inc  = sts_i.out_free;
      end
      default: cmd_o.in_ready = 1'b0;
    endcase
  end

endmodule

### hw/rtl/fct_dpath.sv
// Table memory, request registers, scan pointer and result register.
`include "assert_macros.svh"

module fct_dpath import fct_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_acc_i,
  input  logic [1:0]        op_i,
  input  logic [CODE_W-1:0] fault_code_i,
  input  logic [SEV_W-1:0]  severity_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic              out_stall_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  output logic [1:0]        result_code_o,
  output logic              entry_valid_o,
  output logic [CODE_W-1:0] fault_code_out_o,
  output logic [STAT_W-1:0] status_bits_o,
  output logic [SEV_W-1:0]  severity_out_o,
  output logic [TIME_W-1:0] first_time_o,
  output logic              active_o,
  output logic [CNT_W-1:0]  entry_count_o,
  output logic              last_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  entry_t mem [ENTRIES];

  op_e               req_op_q;
  logic [CODE_W-1:0] req_code_q;
  logic [SEV_W-1:0]  req_sev_q;
  logic [TIME_W-1:0] req_now_q;

  logic [CNT_W-1:0] count_q, ptr_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q, hit_idx_q;
  entry_t           rd_q, ent_q;

  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data, out_ent;
  logic             hit, out_free, out_valid_q;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      req_op_q   <= op_e'(op_i);
      req_code_q <= fault_code_i;
      req_sev_q  <= severity_i;
      req_now_q  <= now_ms_i;
    end
  end

  // Count and slot pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        count_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - 1'b1;
      end
      if (in_acc_i) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_load_hit) begin
        ptr_q <= CNT_W'(rd_idx_q) + 1'b1;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  // Write source.
  always_comb begin
    case (cmd_i.wr_src)
      WR_HIT: begin
        wr_addr        = hit_idx_q;
        wr_data        = ent_q;
        wr_data.status = ent_q.status | ST_TEST_FAILED | ST_CONFIRMED;
      end
      WR_NEW: begin
        wr_addr = count_q[IDX_W-1:0];
        wr_data = '{code: req_code_q, status: ST_TEST_FAILED | ST_CONFIRMED,
                    sev: req_sev_q, first: req_now_q};
      end
      WR_SHIFT: begin
        wr_addr = IDX_W'(rd_idx_q - 1'b1);
        wr_data = rd_q;
      end
      default: begin
        wr_addr = hit_idx_q;
        wr_data = ent_q;
      end
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.rd_en) begin
      rd_q     <= mem[ptr_q[IDX_W-1:0]];
      rd_idx_q <= ptr_q[IDX_W-1:0];
    end
  end

  // Held entry of the current request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_cap) begin
      ent_q     <= rd_q;
      hit_idx_q <= rd_idx_q;
    end else if (cmd_i.wr_en && cmd_i.wr_src != WR_SHIFT) begin
      ent_q <= wr_data;
    end
  end

  assign hit      = rd_vld_q && (rd_q.code == req_code_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o            = '0;
    sts_o.op         = req_op_q;
    sts_o.code_zero  = (req_code_q == '0);
    sts_o.ptr_lt_cnt = (ptr_q < count_q);
    sts_o.rd_vld     = rd_vld_q;
    sts_o.hit        = hit;
    sts_o.cnt_zero   = (count_q == '0);
    sts_o.cnt_full   = (count_q == CNT_W'(ENTRIES));
    sts_o.rpt_last   = (CNT_W'(ptr_q + 1'b1) == count_q);
    sts_o.out_free   = out_free;
  end

  always_comb begin
    case (cmd_i.out_sel)
      SEL_ENT:  out_ent = ent_q;
      SEL_RD:   out_ent = rd_q;
      default:  out_ent = '0;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_code_o    <= cmd_i.out_rc;
      entry_valid_o    <= (cmd_i.out_sel != SEL_NONE);
      fault_code_out_o <= out_ent.code;
      status_bits_o    <= out_ent.status;
      severity_out_o   <= out_ent.sev;
      first_time_o     <= out_ent.first;
      active_o         <= cmd_i.out_act && ((out_ent.status & ST_TEST_FAILED) != '0);
      entry_count_o    <= count_q;
      last_o           <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_STD(a_cnt_range, count_q <= CNT_W'(ENTRIES), "entry count above table size")
  `ASSERT_STD(a_inc_room, cmd_i.cnt_inc |-> count_q < CNT_W'(ENTRIES), "append to full table")
  `ASSERT_STD(a_out_free, cmd_i.out_load |-> out_free, "result overwrites pending transfer")
  `ASSERT_STD(a_shift_idx, (cmd_i.wr_en && (cmd_i.wr_src == WR_SHIFT)) |-> rd_idx_q != '0, "shift from slot zero")

endmodule
